[rtl/core/assert_macros.svh]
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms for the checker files.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Combinational implication, checked at every edge out of reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked at every edge out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/core/arpbcm_pkg.sv]
// ============================================================================
// arpbcm_pkg
// Types and constants shared by the ARP binding monitor files.
// ============================================================================
package arpbcm_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam logic [15:0] OPCODE_REPLY = 16'd2;

    localparam logic ACT_CLEAR   = 1'b0;
    localparam logic ACT_OBSERVE = 1'b1;

    localparam logic [2:0] ST_IGNORED    = 3'd0;
    localparam logic [2:0] ST_LEARNED    = 3'd1;
    localparam logic [2:0] ST_CONSISTENT = 3'd2;
    localparam logic [2:0] ST_CONFLICT   = 3'd3;
    localparam logic [2:0] ST_FULL       = 3'd4;

    typedef struct packed {
        logic        action;
        logic [15:0] arp_opcode;
        logic [31:0] sender_ip;
        logic [47:0] sender_mac;
    } t_arp_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [47:0] stored_mac;
        logic [31:0] reported_ip;
    } t_arp_rsp;

    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
    } t_binding;

endpackage

[rtl/core/arpbcm_table.sv]
// ============================================================================
// arpbcm_table
// Binding store: one write port, one read port with registered data.
// ============================================================================
module arpbcm_table (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [arpbcm_pkg::IDX_W-1:0] i_wr_addr,
    input  arpbcm_pkg::t_binding         i_wr_data,
    input  logic [arpbcm_pkg::IDX_W-1:0] i_rd_addr,
    output arpbcm_pkg::t_binding         o_rd_data
);
    import arpbcm_pkg::*;

    t_binding r_mem [TABLE_ENTRIES];
    t_binding r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/arp_binding_conflict_monitor.sv]
// ============================================================================
// arp_binding_conflict_monitor
// IP-to-MAC binding table that flags conflicting ARP replies.
// ============================================================================
// A request is taken when i_start is high and o_busy is low. Every request
// yields exactly one result, shown for one cycle with o_strobe high; the
// receiver cannot stall, so results must be captured as they appear. A
// clear, or an observe whose opcode is not a reply, is answered in the next
// cycle and o_busy stays low. A reply walks the stored bindings one per cycle
// through a single read port and a single IP comparator, and answers at the
// first hit or, on a miss, once every valid binding has been compared
// (with no read on an empty table). Bindings are appended in order and a
// fill count marks the valid ones, so a clear only resets the count.
// ============================================================================
module arp_binding_conflict_monitor (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  arpbcm_pkg::t_arp_req i_req,
    output logic                 o_busy,
    output logic                 o_strobe,
    output arpbcm_pkg::t_arp_rsp o_rsp
);
    import arpbcm_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_fill, n_fill;     // number of valid bindings
    logic [CNT_W-1:0] r_addr, n_addr;     // next entry to read
    logic             r_cmp_vld, n_cmp_vld; // read data is for a live entry
    logic [31:0]      r_ip, n_ip;
    logic [47:0]      r_mac, n_mac;
    logic             r_strobe, n_strobe;
    t_arp_rsp         r_rsp, n_rsp;

    logic     accept;
    logic     rd_en;
    logic     hit;
    logic     wr_en;
    t_binding wr_data;
    t_binding rd_data;

    arpbcm_table u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_fill[IDX_W-1:0]),
        .i_wr_data (wr_data),
        .i_rd_addr (r_addr[IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    assign accept  = i_start && (r_state == S_IDLE);
    assign rd_en   = (r_state == S_SCAN) && (r_addr < r_fill);
    // the shared comparator: stored IP vs. the request's IP
    assign hit     = r_cmp_vld && (rd_data.ip == r_ip);
    assign wr_data = '{ip: r_ip, mac: r_mac};

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_addr    = r_addr;
        n_cmp_vld = 1'b0;
        n_ip      = r_ip;
        n_mac     = r_mac;
        n_strobe  = 1'b0;
        n_rsp     = r_rsp;
        wr_en     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_ip  = i_req.sender_ip;
                    n_mac = i_req.sender_mac;
                    if (i_req.action == ACT_CLEAR) begin
                        n_fill   = '0;
                        n_strobe = 1'b1;
                        n_rsp    = '{status: ST_IGNORED, stored_mac: '0, reported_ip: '0};
                    end else if (i_req.arp_opcode != OPCODE_REPLY) begin
                        n_strobe = 1'b1;
                        n_rsp    = '{status: ST_IGNORED, stored_mac: '0,
                                     reported_ip: i_req.sender_ip};
                    end else begin
                        n_state = S_SCAN;
                        n_addr  = '0;
                    end
                end
            end
            S_SCAN: begin
                if (hit) begin
                    n_state  = S_IDLE;
                    n_strobe = 1'b1;
                    n_rsp.status      = (rd_data.mac == r_mac) ? ST_CONSISTENT : ST_CONFLICT;
                    n_rsp.stored_mac  = rd_data.mac;
                    n_rsp.reported_ip = r_ip;
                end else if (rd_en) begin
                    n_addr    = r_addr + 1'b1;
                    n_cmp_vld = 1'b1;
                end else if (!r_cmp_vld) begin
                    // every valid entry compared without a match
                    n_state  = S_IDLE;
                    n_strobe = 1'b1;
                    n_rsp.stored_mac  = '0;
                    n_rsp.reported_ip = r_ip;
                    if (r_fill >= CNT_W'(TABLE_ENTRIES)) begin
                        n_rsp.status = ST_FULL;
                    end else begin
                        wr_en        = 1'b1;
                        n_fill       = r_fill + 1'b1;
                        n_rsp.status = ST_LEARNED;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_addr    <= '0;
            r_cmp_vld <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_addr    <= n_addr;
            r_cmp_vld <= n_cmp_vld;
            r_strobe  <= n_strobe;
        end
        r_ip  <= n_ip;
        r_mac <= n_mac;
        r_rsp <= n_rsp;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule

[rtl/core/arpbcm_checker.sv]
// ============================================================================
// arpbcm_checker
// Port-level checks on the ARP binding monitor, bound to the top level.
// ============================================================================
`include "assert_macros.svh"

module arpbcm_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_start,
    input arpbcm_pkg::t_arp_req i_req,
    input logic                 o_busy,
    input logic                 o_strobe,
    input arpbcm_pkg::t_arp_rsp o_rsp
);
    import arpbcm_pkg::*;

    logic        req_take;
    logic        clear_take;
    logic        ignore_take;
    logic        take_reply;
    logic [31:0] r_req_ip;
    logic        clear_seen;
    logic        echo_seen;
    logic        rsp_plain;
    logic        rsp_clean;

    // request IP as of the previous edge
    always_ff @(posedge i_clk) begin
        r_req_ip <= i_req.sender_ip;
    end

    assign req_take    = i_start && !o_busy;
    assign clear_take  = req_take && (i_req.action == ACT_CLEAR);
    assign ignore_take = req_take && (i_req.action == ACT_OBSERVE)
                         && (i_req.arp_opcode != OPCODE_REPLY);
    assign take_reply  = req_take && (i_req.action == ACT_OBSERVE)
                         && (i_req.arp_opcode == OPCODE_REPLY);

    assign clear_seen = o_strobe && (o_rsp.status == ST_IGNORED)
                        && (o_rsp.reported_ip == 32'd0) && !o_busy;
    assign echo_seen  = o_strobe && (o_rsp.status == ST_IGNORED)
                        && (o_rsp.reported_ip == r_req_ip);
    assign rsp_plain  = o_strobe && (o_rsp.status != ST_CONSISTENT)
                        && (o_rsp.status != ST_CONFLICT);
    assign rsp_clean  = (o_rsp.stored_mac == 48'd0) && (o_rsp.status <= ST_FULL);

    // a clear answers in the next cycle with an ignored, zero-IP result
    `ASSERT_NEXT(a_clear_rsp, i_clk, i_rst_n, clear_take, clear_seen)

    // a non-reply is ignored at once and echoes its IP
    `ASSERT_NEXT(a_ignore_rsp, i_clk, i_rst_n, ignore_take, echo_seen)

    // a reply always starts a table walk
    `ASSERT_NEXT(a_reply_busy, i_clk, i_rst_n, take_reply, o_busy && !o_strobe)

    // only consistent or conflict results carry a stored MAC
    `ASSERT_IMPL(a_mac_zero, i_clk, i_rst_n, rsp_plain, rsp_clean)

endmodule

bind arp_binding_conflict_monitor arpbcm_checker u_arpbcm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .i_req    (i_req),
    .o_busy   (o_busy),
    .o_strobe (o_strobe),
    .o_rsp    (o_rsp)
);

[sim/arp_binding_conflict_monitor_test.sv]
`timescale 1ns / 1ps
// ============================================================================
// arp_binding_conflict_monitor_test
// Self-checking bench for the ARP binding monitor: a short table of directed
// requests, then random episodes of ARP replies that learn, repeat, conflict
// with and overflow the binding table. Every result is compared against a
// hand-written expectation or a shadow binding table kept in the bench.
// ============================================================================
module arp_binding_conflict_monitor_test;

    import arpbcm_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 11;
    localparam int ITEM_TARGET   = 1200;
    // Worst case per request: full table scan plus the longest sender gap.
    localparam int CYCLE_LIMIT   = 600000;
    localparam int DRAIN_CYCLES  = TABLE_ENTRIES + 8;
    localparam int REPORT_LIMIT  = 10;

    typedef struct {
        t_arp_req req;
        bit       typed;
        t_arp_rsp want;
    } t_stim_row;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_start;
    t_arp_req i_req;
    logic     o_busy;
    logic     o_strobe;
    t_arp_rsp o_rsp;

    arp_binding_conflict_monitor u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_req    (i_req),
        .o_busy   (o_busy),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp)
    );

    // Shadow copy of the binding table: entries 0..shadow_fill-1 are valid.
    logic [31:0] shadow_ip  [TABLE_ENTRIES];
    logic [47:0] shadow_mac [TABLE_ENTRIES];
    int          shadow_fill;

    // Verdicts still owed by the block, oldest first.
    t_arp_rsp    owed_verdicts[$];
    t_stim_row   directed_rows[$];

    // Hand-written expectation for the request now being offered.
    bit          use_typed;
    t_arp_rsp    typed_want;

    int unsigned accepted_count;
    int unsigned error_count;
    int unsigned cycle_count;
    int          burst_left;

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial i_clk = 1'b0;
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Binding table predictor. Updates the shadow table and returns the
    // verdict the block should give for this request.
    // ------------------------------------------------------------------------
    function automatic t_arp_rsp resolve_arp(t_arp_req r);
        t_arp_rsp v;
        v = '0;
        if (r.action == ACT_CLEAR) begin
            // Clear: table emptied, verdict is all zero (no IP echo).
            shadow_fill = 0;
            return v;
        end
        v.reported_ip = r.sender_ip;
        if (r.arp_opcode != OPCODE_REPLY)
            return v;
        // Linear scan in fill order; first binding for an IP wins.
        for (int k = 0; k < shadow_fill; k++) begin
            if (shadow_ip[IDX_W'(k)] == r.sender_ip) begin
                v.status     = (shadow_mac[IDX_W'(k)] == r.sender_mac) ? ST_CONSISTENT
                                                                        : ST_CONFLICT;
                v.stored_mac = shadow_mac[IDX_W'(k)];
                return v;
            end
        end
        if (shadow_fill >= TABLE_ENTRIES) begin
            // Unknown IP with no room left: dropped.
            v.status = ST_FULL;
            return v;
        end
        shadow_ip[IDX_W'(shadow_fill)]  = r.sender_ip;
        shadow_mac[IDX_W'(shadow_fill)] = r.sender_mac;
        shadow_fill++;
        v.status = ST_LEARNED;
        return v;
    endfunction

    task automatic flag_error(string msg);
        if (error_count < REPORT_LIMIT)
            $display("[%0t] ERROR: %s", $realtime, msg);
        error_count++;
    endtask

    // ------------------------------------------------------------------------
    // Monitor: checks strobed results, then predicts for an accepted request.
    // A result strobed on the same edge as an acceptance belongs to an older
    // request, so the check comes first.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_arp_rsp want;
        t_arp_rsp pred;
        if (i_rst_n) begin
            if (o_strobe !== 1'b0) begin
                if (owed_verdicts.size() == 0) begin
                    flag_error($sformatf("result with none owed: st=%0d mac=%h ip=%h",
                                         o_rsp.status, o_rsp.stored_mac,
                                         o_rsp.reported_ip));
                end else begin
                    want = owed_verdicts.pop_front();
                    if (o_rsp.status !== want.status ||
                        o_rsp.stored_mac !== want.stored_mac ||
                        o_rsp.reported_ip !== want.reported_ip) begin
                        flag_error($sformatf(
                            "mismatch: st %0d/%0d mac %h/%h ip %h/%h (exp/act)",
                            want.status, o_rsp.status,
                            want.stored_mac, o_rsp.stored_mac,
                            want.reported_ip, o_rsp.reported_ip));
                    end
                end
            end
            if (i_start === 1'b1 && o_busy === 1'b0) begin
                pred = resolve_arp(i_req);
                owed_verdicts.push_back(use_typed ? typed_want : pred);
                accepted_count++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [47:0] random_mac();
        logic [31:0] hi;
        logic [31:0] lo;
        hi = $urandom;
        lo = $urandom;
        return {hi[15:0], lo};
    endfunction

    task automatic add_row(logic act, logic [15:0] op, logic [31:0] ip,
                           logic [47:0] mac, bit typed, logic [2:0] st,
                           logic [47:0] smac, logic [31:0] rip);
        t_stim_row row;
        row.req.action       = act;
        row.req.arp_opcode   = op;
        row.req.sender_ip    = ip;
        row.req.sender_mac   = mac;
        row.typed            = typed;
        row.want.status      = st;
        row.want.stored_mac  = smac;
        row.want.reported_ip = rip;
        directed_rows.push_back(row);
    endtask

    // Offer one request (called at a falling edge) and hold it until taken.
    // The sender works in bursts; between bursts start usually drops for a while.
    task automatic send_request(t_arp_req r, bit typed, t_arp_rsp want);
        int unsigned target;
        if (burst_left <= 0) begin
            if ($urandom_range(0, 99) >= 30) begin
                i_start <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        use_typed  = typed;
        typed_want = want;
        target     = accepted_count + 1;
        i_req   <= r;
        i_start <= 1'b1;
        do @(negedge i_clk); while (accepted_count != target);
    endtask

    // One random item for the current episode. Mostly replies that either
    // learn a fresh IP or revisit a stored one; the rest is noise.
    function automatic t_arp_req make_random_req();
        t_arp_req r;
        int       pick;
        int       k;
        r.action     = ACT_OBSERVE;
        r.arp_opcode = OPCODE_REPLY;
        r.sender_ip  = $urandom;
        r.sender_mac = random_mac();
        pick = $urandom_range(0, 99);
        if (pick < 1) begin
            // stray clear with junk payload
            r.action     = ACT_CLEAR;
            r.arp_opcode = 16'($urandom_range(0, 65535));
        end else if (pick < 11) begin
            r.arp_opcode = 16'($urandom_range(0, 65535));
            if (r.arp_opcode == OPCODE_REPLY)
                r.arp_opcode = r.arp_opcode ^ 16'h0100;
            if (shadow_fill > 0 && pick < 6)
                r.sender_ip = shadow_ip[IDX_W'($urandom_range(0, shadow_fill - 1))];
        end else if (pick < 55 || shadow_fill == 0) begin
            // fresh IP; sometimes one bit away from a stored one
            if (shadow_fill > 0 && pick < 20)
                r.sender_ip = shadow_ip[IDX_W'($urandom_range(0, shadow_fill - 1))]
                              ^ (32'd1 << $urandom_range(0, 31));
        end else begin
            k = $urandom_range(0, shadow_fill - 1);
            r.sender_ip = shadow_ip[IDX_W'(k)];
            if (pick < 80)
                r.sender_mac = shadow_mac[IDX_W'(k)];
            else if (pick < 90)
                r.sender_mac = shadow_mac[IDX_W'(k)] ^ (48'd1 << $urandom_range(0, 47));
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_arp_req clear_req;
        t_arp_req r;
        t_arp_rsp none;
        int       items_sent;
        int       episode_left;

        i_rst_n        = 1'b0;
        i_start        = 1'b0;
        i_req          = '0;
        use_typed      = 1'b0;
        typed_want     = '0;
        accepted_count = 0;
        error_count    = 0;
        cycle_count    = 0;
        shadow_fill    = 0;
        burst_left     = 0;
        none           = '0;

        // Directed table: extremes, every opcode class, all verdicts but full.
        add_row(ACT_CLEAR,   16'hFFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                1, ST_IGNORED, 48'h0, 32'h0);
        add_row(ACT_OBSERVE, 16'h0000, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                1, ST_IGNORED, 48'h0, 32'hFFFF_FFFF);
        add_row(ACT_OBSERVE, 16'hFFFF, 32'h0000_0000, 48'h0,
                1, ST_IGNORED, 48'h0, 32'h0);
        add_row(ACT_OBSERVE, 16'h0001, 32'h0A00_0001, 48'h0200_0000_0001,
                1, ST_IGNORED, 48'h0, 32'h0A00_0001);
        add_row(ACT_OBSERVE, 16'h8002, 32'h0A00_0002, 48'h0200_0000_0002,
                1, ST_IGNORED, 48'h0, 32'h0A00_0002);
        add_row(ACT_OBSERVE, OPCODE_REPLY, 32'h0, 48'h0,
                1, ST_LEARNED, 48'h0, 32'h0);
        add_row(ACT_OBSERVE, OPCODE_REPLY, 32'h0, 48'h0,
                1, ST_CONSISTENT, 48'h0, 32'h0);
        add_row(ACT_OBSERVE, OPCODE_REPLY, 32'h0, 48'hFFFF_FFFF_FFFF,
                1, ST_CONFLICT, 48'h0, 32'h0);
        add_row(ACT_OBSERVE, OPCODE_REPLY, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                1, ST_LEARNED, 48'h0, 32'hFFFF_FFFF);
        add_row(ACT_OBSERVE, OPCODE_REPLY, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                1, ST_CONSISTENT, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        add_row(ACT_OBSERVE, OPCODE_REPLY, 32'hFFFF_FFFF, 48'h0,
                1, ST_CONFLICT, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        add_row(ACT_OBSERVE, OPCODE_REPLY, 32'hC0A8_0001, 48'h0011_2233_4455,
                0, ST_IGNORED, 48'h0, 32'h0);
        add_row(ACT_OBSERVE, OPCODE_REPLY, 32'hC0A8_0001, 48'h0011_2233_4454,
                0, ST_IGNORED, 48'h0, 32'h0);
        add_row(ACT_OBSERVE, OPCODE_REPLY, 32'hC0A8_0000, 48'h0011_2233_4455,
                0, ST_IGNORED, 48'h0, 32'h0);
        add_row(ACT_OBSERVE, OPCODE_REPLY, 32'h0, 48'h0,
                0, ST_IGNORED, 48'h0, 32'h0);
        // clear carrying a reply opcode still clears
        add_row(ACT_CLEAR,   OPCODE_REPLY, 32'h1234_5678, 48'hAAAA_5555_AAAA,
                1, ST_IGNORED, 48'h0, 32'h0);
        add_row(ACT_OBSERVE, OPCODE_REPLY, 32'hFFFF_FFFF, 48'h0,
                1, ST_LEARNED, 48'h0, 32'hFFFF_FFFF);
        add_row(ACT_OBSERVE, OPCODE_REPLY, 32'hFFFF_FFFF, 48'h0,
                1, ST_CONSISTENT, 48'h0, 32'hFFFF_FFFF);
        // non-reply on a known IP leaves the binding alone
        add_row(ACT_OBSERVE, 16'h0102, 32'hFFFF_FFFF, 48'h5555_AAAA_5555,
                1, ST_IGNORED, 48'h0, 32'hFFFF_FFFF);
        add_row(ACT_OBSERVE, OPCODE_REPLY, 32'hFFFF_FFFF, 48'h0000_0000_0123,
                1, ST_CONFLICT, 48'h0, 32'hFFFF_FFFF);
        add_row(ACT_OBSERVE, OPCODE_REPLY, 32'h5555_AAAA, 48'hAAAA_5555_AAAA,
                0, ST_IGNORED, 48'h0, 32'h0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed,
                         directed_rows[i].want);

        // Random episodes: each opens with a clear, then runs long enough
        // that about a third of them fill the table and hit the full case.
        clear_req            = '0;
        clear_req.action     = ACT_CLEAR;
        items_sent           = 0;
        episode_left         = 0;
        while (items_sent < ITEM_TARGET) begin
            if (episode_left <= 0) begin
                clear_req.sender_ip = $urandom;
                send_request(clear_req, 0, none);
                episode_left = ($urandom_range(0, 2) == 0) ? $urandom_range(150, 260)
                                                           : $urandom_range(20, 120);
            end else begin
                r = make_random_req();
                send_request(r, 0, none);
                episode_left--;
            end
            items_sent++;
        end

        i_start <= 1'b0;
        while (owed_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (owed_verdicts.size() != 0)
            flag_error($sformatf("%0d results never arrived", owed_verdicts.size()));

        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
